[sv/emb_pkg.sv]
// elevation map sampler: shared constants, register codes and the texel fetch table
// no dependencies
package emb_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int ROOT_BITS      = 31;
    localparam int HEIGHT_BITS    = 41;
    localparam int RELIEF_BITS    = 40;
    localparam int ACC_BITS       = 57;
    localparam int WEIGHT_BITS    = 16;
    localparam int ADDR_IN_BITS   = 18;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 36;
    localparam int FETCH_COUNT    = 12;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_WIDTH     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_HEIGHT    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT_SCALE  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT_OFFSET = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_PRESENT   = 3'd4;

    // patch slot = row * 4 + column, relative to one texel up and left of the base corner
    function automatic logic [3:0] fetch_slot(input logic [3:0] k);
        logic [3:0] slot;
        case (k)
            4'd0:    slot = 4'd4;
            4'd1:    slot = 4'd5;
            4'd2:    slot = 4'd6;
            4'd3:    slot = 4'd7;
            4'd4:    slot = 4'd8;
            4'd5:    slot = 4'd9;
            4'd6:    slot = 4'd10;
            4'd7:    slot = 4'd11;
            4'd8:    slot = 4'd1;
            4'd9:    slot = 4'd2;
            4'd10:   slot = 4'd13;
            4'd11:   slot = 4'd14;
            default: slot = 4'd0;
        endcase
        return slot;
    endfunction

endpackage

[sv/emb_store.sv]
// sample store: single write port, single read port with registered read data
// no dependencies
module emb_store #(
    parameter int WORDS = 262144,
    parameter int ADDR_BITS = $clog2(WORDS)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [15:0]          wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [15:0]          rd_data
);

    logic [15:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/emb_isqrt.sv]
// one relief lane: sum of squared central differences, then a bit-serial square root
// depends on emb_pkg
module emb_isqrt (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [emb_pkg::SAMPLE_BITS:0] dx,
    input  logic signed [emb_pkg::SAMPLE_BITS:0] dy,
    output logic                                busy,
    output logic [emb_pkg::ROOT_BITS-1:0]       root
);

    localparam int VAL_BITS = 2 * emb_pkg::ROOT_BITS;
    localparam int REM_BITS = emb_pkg::ROOT_BITS + 4;

    logic                              busy_reg, prep_reg;
    logic [4:0]                        cnt_reg;
    logic [VAL_BITS-1:0]               val_reg;
    logic [REM_BITS-1:0]               rem_reg;
    logic [emb_pkg::ROOT_BITS-1:0]     root_reg;
    logic signed [33:0]                sq_sum;
    logic [REM_BITS-1:0]               rem_sh, trial;

    assign sq_sum = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
    assign rem_sh = {rem_reg[REM_BITS-3:0], val_reg[VAL_BITS-1 -: 2]};
    assign trial  = REM_BITS'({root_reg, 2'b01});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            prep_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            prep_reg <= 1'b1;
        end else if (busy_reg) begin
            if (prep_reg) begin
                prep_reg <= 1'b0;
                cnt_reg  <= 5'(emb_pkg::ROOT_BITS - 1);
            end else begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && prep_reg) begin
            // value is (dx^2 + dy^2) scaled by 2^29
            val_reg  <= {sq_sum[32:0], 29'd0};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg <= val_reg << 2;
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[emb_pkg::ROOT_BITS-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[emb_pkg::ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

[sv/emb_blend.sv]
// bilinear blend and scaling on one shared multiply-accumulate unit, height pass then relief pass
// depends on emb_pkg
module emb_blend (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          start,
    input  logic [emb_pkg::WEIGHT_BITS-1:0]               tx,
    input  logic [emb_pkg::WEIGHT_BITS-1:0]               ty,
    input  logic [3:0][emb_pkg::SAMPLE_BITS-1:0]          raw,
    input  logic [3:0][emb_pkg::ROOT_BITS-1:0]            rel,
    input  logic [23:0]                                   scale,
    input  logic signed [35:0]                            offset,
    output logic                                          busy,
    output logic signed [emb_pkg::HEIGHT_BITS-1:0]        height_out,
    output logic [emb_pkg::RELIEF_BITS-1:0]               relief_out
);

    localparam int AB = emb_pkg::ACC_BITS;
    localparam logic [AB-1:0] ROUND = AB'(32768);
    localparam logic signed [42:0] H_MAX = 43'sd1099511627775;
    localparam logic signed [42:0] H_MIN = -43'sd1099511627776;
    localparam logic [40:0] R_MAX = 41'd1099511627775;

    logic              busy_reg, pass_reg, phase_reg;
    logic [2:0]        step_reg;
    logic [AB-1:0]     acc_reg;
    logic [55:0]       prod_reg;
    logic [31:0]       r0_reg, r1_reg, b_reg;
    logic signed [emb_pkg::HEIGHT_BITS-1:0] height_reg;
    logic [emb_pkg::RELIEF_BITS-1:0]        relief_reg;

    logic [3:0][31:0]  qa;
    logic [16:0]       wx0, wy0;
    logic [31:0]       opa;
    logic [23:0]       opb;
    logic [AB-1:0]     acc_sum;
    logic [40:0]       res;
    logic signed [42:0] hsum;
    logic              grp_end;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qa[i] = pass_reg ? {1'b0, rel[i]} : {raw[i], 16'd0};
        end
    end

    assign wx0 = 17'd65536 - {1'b0, tx};
    assign wy0 = 17'd65536 - {1'b0, ty};

    always_comb begin
        case (step_reg)
            3'd0:    begin opa = qa[0]; opb = 24'(wx0); end
            3'd1:    begin opa = qa[1]; opb = 24'(tx);  end
            3'd2:    begin opa = qa[2]; opb = 24'(wx0); end
            3'd3:    begin opa = qa[3]; opb = 24'(tx);  end
            3'd4:    begin opa = r0_reg; opb = 24'(wy0); end
            3'd5:    begin opa = r1_reg; opb = 24'(ty);  end
            3'd6:    begin opa = b_reg;  opb = scale;    end
            default: begin opa = '0;     opb = '0;       end
        endcase
    end

    assign acc_sum = acc_reg + AB'(prod_reg);
    assign res     = acc_sum[AB-1:16];
    assign grp_end = step_reg[0] || (step_reg == 3'd6);
    assign hsum    = $signed({2'b00, res}) + 43'(offset);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            pass_reg  <= 1'b0;
            phase_reg <= 1'b0;
            step_reg  <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            pass_reg  <= 1'b0;
            phase_reg <= 1'b0;
            step_reg  <= '0;
        end else if (busy_reg) begin
            phase_reg <= ~phase_reg;
            if (phase_reg) begin
                if (step_reg == 3'd6) begin
                    step_reg <= '0;
                    pass_reg <= 1'b1;
                    if (pass_reg) begin
                        busy_reg <= 1'b0;
                    end
                end else begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= ROUND;
        end else if (busy_reg && !phase_reg) begin
            prod_reg <= opa * opb;
        end else if (busy_reg) begin
            acc_reg <= grp_end ? ROUND : acc_sum;
            case (step_reg)
                3'd1: r0_reg <= acc_sum[47:16];
                3'd3: r1_reg <= acc_sum[47:16];
                3'd5: b_reg  <= acc_sum[47:16];
                3'd6: begin
                    if (!pass_reg) begin
                        if (hsum > H_MAX) begin
                            height_reg <= 41'(H_MAX);
                        end else if (hsum < H_MIN) begin
                            height_reg <= 41'(H_MIN);
                        end else begin
                            height_reg <= 41'(hsum);
                        end
                    end else begin
                        relief_reg <= (res > R_MAX) ? 40'(R_MAX) : 40'(res);
                    end
                end
                default: ;
            endcase
        end
    end

    assign busy       = busy_reg;
    assign height_out = height_reg;
    assign relief_out = relief_reg;

endmodule

[sv/elevation_map_bilinear_sampler.sv]
// elevation map sampler top level: configuration, texel fetch sequencer, output register
// depends on emb_pkg, emb_store, emb_isqrt, emb_blend
//
// Usage
//   s_ channel: one request per item. action 0 stores sample_value at sample_address
//   (addresses at or beyond the store size are dropped) and gives no result. action 1
//   is a query at lon_fraction / lat_fraction and gives one result on the m_ channel.
//   cfg channel: cfg_index selects width, height, scale, offset or present; always ready.
//   Write only while no query is in flight.
// Processing
//   a write goes straight to the store. A query with the map absent skips the fetch and
//   returns zeros. Any other query passes through one coordinate step, 12 texel read
//   issues and a drain of the address/read pipeline on the single store port, the
//   four parallel bit-serial square root lanes (set-up, one step per root bit and
//   hand-off), the shared multiply-accumulate unit (height pass, then relief pass) and
//   the output register. Only one query is worked on at a time, so a new request is
//   taken only once the last query has reached the output register.
// Reset and stalls
//   reset restores the register defaults and empties the pipeline; the store keeps
//   whatever it held. A stalled m_ channel holds its result; the next request is still
//   taken, and a following query waits at its end until the output register is free.
module elevation_map_bilinear_sampler #(
    parameter int STORE_WORDS = 262144,
    parameter int COORD_FRACTION_BITS = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_action,
    input  logic [emb_pkg::ADDR_IN_BITS-1:0]       s_sample_address,
    input  logic [15:0]                            s_sample_value,
    input  logic [COORD_FRACTION_BITS-1:0]         s_lon_fraction,
    input  logic [COORD_FRACTION_BITS-1:0]         s_lat_fraction,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [emb_pkg::HEIGHT_BITS-1:0] m_height_out,
    output logic [emb_pkg::RELIEF_BITS-1:0]        m_relief_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [emb_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [emb_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int CFB       = COORD_FRACTION_BITS;
    localparam int ADDR_BITS = $clog2(STORE_WORDS);
    localparam int MOD_SHIFT = emb_pkg::ADDR_IN_BITS + ADDR_BITS;
    localparam longint unsigned MOD_MUL =
        ((64'd1 << MOD_SHIFT) + STORE_WORDS - 1) / STORE_WORDS;
    localparam logic [CFB+11:0] HALF = (CFB+12)'(1) << (CFB - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_COORD, ST_FETCH, ST_DRAIN, ST_ROOT, ST_BLEND, ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [10:0]        width_reg;
    logic [8:0]         hgt_reg;
    logic [23:0]        scale_reg;
    logic signed [35:0] offset_reg;
    logic               present_reg;
    logic [10:0]        w_eff;
    logic [8:0]         h_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= 11'd1024;
            hgt_reg     <= 9'd256;
            scale_reg   <= 24'd65536;
            offset_reg  <= '0;
            present_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                emb_pkg::CFG_MAP_WIDTH:     width_reg   <= cfg_data[10:0];
                emb_pkg::CFG_MAP_HEIGHT:    hgt_reg     <= cfg_data[8:0];
                emb_pkg::CFG_HEIGHT_SCALE:  scale_reg   <= cfg_data[23:0];
                emb_pkg::CFG_HEIGHT_OFFSET: offset_reg  <= $signed(cfg_data[35:0]);
                emb_pkg::CFG_MAP_PRESENT:   present_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign w_eff = (width_reg < 11'd4) ? 11'd4 : ((width_reg > 11'd1024) ? 11'd1024 : width_reg);
    assign h_eff = (hgt_reg < 9'd2) ? 9'd2 : ((hgt_reg > 9'd256) ? 9'd256 : hgt_reg);

    // input side
    logic s_acc, wr_en;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign wr_en   = s_acc && !s_action && (32'(s_sample_address) < 32'(STORE_WORDS));

    logic [CFB-1:0] lon_reg, lat_reg;
    logic           zero_reg, zero_next;
    logic [10:0]    xb_reg;
    logic [8:0]     yb_reg;
    logic [15:0]    tx_reg, ty_reg;
    logic [CFB+11:0] px;
    logic [CFB+11:0] py;

    assign px = (CFB+12)'(lon_reg) * (CFB+12)'(w_eff) + HALF;
    assign py = (CFB+12)'(lat_reg) * (CFB+12)'(h_eff) + HALF;

    always_ff @(posedge aclk) begin
        if (s_acc && s_action) begin
            lon_reg <= s_lon_fraction;
            lat_reg <= s_lat_fraction;
        end
        if (state_reg == ST_COORD) begin
            xb_reg <= px[CFB+10:CFB];
            yb_reg <= py[CFB+8:CFB];
            // fraction to a 16-bit weight, truncating or zero padding
            tx_reg <= 16'({px[CFB-1:0], 16'd0} >> CFB);
            ty_reg <= 16'({py[CFB-1:0], 16'd0} >> CFB);
        end
    end

    // fetch address generation: wrap columns, clamp rows, fold into the store
    logic [3:0]  k_reg, k_next;
    logic [3:0]  iss_slot;
    logic [12:0] col_b;
    logic [9:0]  row_b;
    logic [10:0] col;
    logic [7:0]  row;
    logic        iss_v;

    assign iss_v    = (state_reg == ST_FETCH);
    assign iss_slot = emb_pkg::fetch_slot(k_reg);
    assign col_b    = 13'(xb_reg) + 13'(iss_slot[1:0]);
    assign row_b    = 10'(yb_reg) + 10'(iss_slot[3:2]);

    always_comb begin
        if (col_b < 13'd2) begin
            col = 11'(col_b + 13'(w_eff) - 13'd2);
        end else if (col_b >= 13'(w_eff) + 13'd2) begin
            col = 11'(col_b - 13'd2 - 13'(w_eff));
        end else begin
            col = 11'(col_b - 13'd2);
        end
        if (row_b < 10'd2) begin
            row = '0;
        end else if (row_b - 10'd2 >= 10'(h_eff)) begin
            row = 8'(h_eff - 9'd1);
        end else begin
            row = 8'(row_b - 10'd2);
        end
    end

    logic        a1_v, a2_v, a3_v;
    logic [3:0]  a1_slot, a2_slot, a3_slot;
    logic [17:0] a1_prod, a2_prod, a2_q;
    logic [37:0] q_wide;
    logic [35:0] q_times;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [15:0] rd_data;

    assign q_wide  = 38'(a1_prod) * 38'(MOD_MUL);
    assign q_times = 36'(a2_q) * 36'(STORE_WORDS);
    assign rd_addr = ADDR_BITS'(a2_prod - 18'(q_times));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a1_v <= 1'b0;
            a2_v <= 1'b0;
            a3_v <= 1'b0;
        end else begin
            a1_v <= iss_v;
            a2_v <= a1_v;
            a3_v <= a2_v;
        end
    end

    always_ff @(posedge aclk) begin
        a1_prod <= 18'(19'(row) * 19'(w_eff) + 19'(col));
        a1_slot <= iss_slot;
        a2_prod <= a1_prod;
        a2_q    <= 18'(q_wide >> MOD_SHIFT);
        a2_slot <= a1_slot;
        a3_slot <= a2_slot;
    end

    emb_store #(
        .WORDS(STORE_WORDS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_BITS'(s_sample_address)),
        .wr_data (s_sample_value),
        .rd_en   (a2_v),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // 4x4 patch around the base corner, corners of the patch unused
    logic [15:0] tex_reg [16];

    always_ff @(posedge aclk) begin
        if (a3_v) begin
            tex_reg[a3_slot] <= rd_data;
        end
    end

    // relief lanes, one per interpolation corner
    logic [3:0]  lane_busy;
    logic        lane_start;
    logic [3:0][emb_pkg::ROOT_BITS-1:0] lane_root;
    logic [3:0][15:0] corner_raw;

    for (genvar j = 0; j < 4; j++) begin : g_lane
        localparam int C = 1 + (j % 2);
        localparam int R = 1 + (j / 2);
        logic signed [16:0] ldx, ldy;
        assign ldx = $signed({1'b0, tex_reg[R*4 + C + 1]}) - $signed({1'b0, tex_reg[R*4 + C - 1]});
        assign ldy = $signed({1'b0, tex_reg[(R+1)*4 + C]}) - $signed({1'b0, tex_reg[(R-1)*4 + C]});
        assign corner_raw[j] = tex_reg[R*4 + C];

        emb_isqrt u_isqrt (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (lane_start),
            .dx      (ldx),
            .dy      (ldy),
            .busy    (lane_busy[j]),
            .root    (lane_root[j])
        );
    end

    logic blend_start, blend_busy;
    logic signed [emb_pkg::HEIGHT_BITS-1:0] blend_height;
    logic [emb_pkg::RELIEF_BITS-1:0]        blend_relief;

    emb_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (blend_start),
        .tx         (tx_reg),
        .ty         (ty_reg),
        .raw        (corner_raw),
        .rel        (lane_root),
        .scale      (scale_reg),
        .offset     (offset_reg),
        .busy       (blend_busy),
        .height_out (blend_height),
        .relief_out (blend_relief)
    );

    // sequencer and output register
    logic m_valid_reg, m_valid_next;
    logic signed [emb_pkg::HEIGHT_BITS-1:0] height_reg, height_next;
    logic [emb_pkg::RELIEF_BITS-1:0]        relief_reg, relief_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        zero_next    = zero_reg;
        m_valid_next = m_valid_reg && !m_ready;
        height_next  = height_reg;
        relief_next  = relief_reg;
        lane_start   = 1'b0;
        blend_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_action) begin
                    zero_next  = !present_reg;
                    state_next = present_reg ? ST_COORD : ST_FINISH;
                end
            end
            ST_COORD: begin
                k_next     = '0;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                k_next = k_reg + 4'd1;
                if (k_reg == 4'(emb_pkg::FETCH_COUNT - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!a1_v && !a2_v && !a3_v) begin
                    lane_start = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (lane_busy == '0) begin
                    blend_start = 1'b1;
                    state_next  = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (!blend_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    height_next  = zero_reg ? '0 : blend_height;
                    relief_next  = zero_reg ? '0 : blend_relief;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            zero_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            zero_reg    <= zero_next;
            m_valid_reg <= m_valid_next;
        end
        height_reg <= height_next;
        relief_reg <= relief_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_height_out = height_reg;
    assign m_relief_out = relief_reg;

`ifndef NO_ASSERTIONS
    a_store_read_in_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        a2_v |-> (state_reg == ST_FETCH || state_reg == ST_DRAIN))
        else $error("store read outside texel fetch");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !((lane_busy != '0) && blend_busy))
        else $error("root lanes and blend unit active together");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");
`endif

endmodule
